[design/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Transaction types, surrogate ranges and UTF-8 lead-byte constants for the
// encoder; its port checker uses the byte transaction type.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	// One UTF-16 code unit with its end-of-string flag.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
	} unit_item_t;

	// One UTF-8 byte with its end markers.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       string_end;
	} byte_item_t;

	// Bytes of one encoded code point, first byte in slot zero.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} cp_bytes_t;

	// Surrogate ranges.
	localparam logic [15:0] SURR_HIGH_FIRST = 16'hd800;
	localparam logic [15:0] SURR_HIGH_LAST  = 16'hdbff;
	localparam logic [15:0] SURR_LOW_FIRST  = 16'hdc00;
	localparam logic [15:0] SURR_LOW_LAST   = 16'hdfff;

	// Upper six bits of a high surrogate, used to rebuild a held one.
	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;

	// Offset of the supplementary planes, in units of 1024 code points.
	localparam logic [10:0] SUPP_BASE_KB = 11'h040;

	// Largest code point for each encoded length.
	localparam logic [20:0] CP_MAX_ONE   = 21'h00007f;
	localparam logic [20:0] CP_MAX_TWO   = 21'h0007ff;
	localparam logic [20:0] CP_MAX_THREE = 21'h00ffff;

	// Lead-byte and continuation prefixes.
	localparam logic [2:0] LEAD_TWO   = 3'b110;
	localparam logic [3:0] LEAD_THREE = 4'b1110;
	localparam logic [4:0] LEAD_FOUR  = 5'b11110;
	localparam logic [1:0] CONT_TAG   = 2'b10;

	// Most bytes one code unit can release: a flushed surrogate plus a
	// three-byte unit.
	localparam int unsigned MAX_BYTES = 6;

endpackage

[design/utf16_to_utf8_encoder_top.sv]
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Converts a stream of UTF-16 code units into UTF-8 bytes, pairing surrogates
// and passing lone surrogates through as three-byte sequences.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction                       | Handshake
//  --------+-----------+-----------------------------------+----------------------
//  unit    | in        | code_unit, final_unit             | unit_valid/unit_ready
//  byte    | out       | out_byte, run_end, string_end     | byte_valid/byte_ready
//
// A code unit is registered, then encoded into a byte buffer of up to six
// bytes, which drains at one byte per cycle while byte_ready is high. An item
// yields one to six bytes, none for a held high surrogate; the single output
// byte per cycle sets the sustained rate.
// The input register takes a new unit while the buffer still drains.
// arst_n clears the held surrogate and all valid flags.
// A stall on byte_ready holds the current byte and backs up into unit_ready.
//
module utf16_to_utf8_encoder_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   unit_valid,
	output logic                   unit_ready,
	input  u16u8_pkg::unit_item_t  unit_data,
	output logic                   byte_valid,
	input  logic                   byte_ready,
	output u16u8_pkg::byte_item_t  byte_data
);

	// Encode one code point into one to four UTF-8 bytes.
	function automatic u16u8_pkg::cp_bytes_t encode_cp(input logic [20:0] cp);
		u16u8_pkg::cp_bytes_t r;
		r.bytes = '0;
		r.count = 3'd0;
		priority if (cp <= u16u8_pkg::CP_MAX_ONE) begin
			r.bytes[0] = cp[7:0];
			r.count    = 3'd1;
		end else if (cp <= u16u8_pkg::CP_MAX_TWO) begin
			r.bytes[0] = {u16u8_pkg::LEAD_TWO, cp[10:6]};
			r.bytes[1] = {u16u8_pkg::CONT_TAG, cp[5:0]};
			r.count    = 3'd2;
		end else if (cp <= u16u8_pkg::CP_MAX_THREE) begin
			r.bytes[0] = {u16u8_pkg::LEAD_THREE, cp[15:12]};
			r.bytes[1] = {u16u8_pkg::CONT_TAG, cp[11:6]};
			r.bytes[2] = {u16u8_pkg::CONT_TAG, cp[5:0]};
			r.count    = 3'd3;
		end else begin
			r.bytes[0] = {u16u8_pkg::LEAD_FOUR, cp[20:18]};
			r.bytes[1] = {u16u8_pkg::CONT_TAG, cp[17:12]};
			r.bytes[2] = {u16u8_pkg::CONT_TAG, cp[11:6]};
			r.bytes[3] = {u16u8_pkg::CONT_TAG, cp[5:0]};
			r.count    = 3'd4;
		end
		return r;
	endfunction

	// Input stage.
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        fin_s1;

	// Byte buffer stage.
	logic       valid_s2;
	logic [7:0] bytes_s2 [u16u8_pkg::MAX_BYTES];
	logic [2:0] cnt_s2;
	logic [2:0] idx_s2;
	logic       fin_s2;

	// Held high surrogate.
	logic       held_valid_q;
	logic [9:0] held_bits_q;

	// Encoder signals.
	logic                 is_high;
	logic                 is_low;
	logic                 pair;
	logic                 flush;
	logic                 hold;
	logic [20:0]          pair_cp;
	u16u8_pkg::cp_bytes_t held_enc;
	u16u8_pkg::cp_bytes_t unit_enc;
	logic [2:0]           unit_cnt;
	logic [7:0]           enc_bytes [u16u8_pkg::MAX_BYTES];
	logic [2:0]           enc_cnt;

	// Handshake signals.
	logic take;
	logic last_byte;
	logic buf_free;
	logic consume;

	// Classify the registered unit against the held surrogate.
	always_comb begin
		is_high = (unit_s1 >= u16u8_pkg::SURR_HIGH_FIRST) &&
		          (unit_s1 <= u16u8_pkg::SURR_HIGH_LAST);
		is_low  = (unit_s1 >= u16u8_pkg::SURR_LOW_FIRST) &&
		          (unit_s1 <= u16u8_pkg::SURR_LOW_LAST);
		pair    = held_valid_q && is_low;
		flush   = held_valid_q && !is_low;
		hold    = !pair && is_high && !fin_s1;
		pair_cp = {{1'b0, held_bits_q} + u16u8_pkg::SUPP_BASE_KB, unit_s1[9:0]};
	end

	// Build the byte list: a flushed surrogate first, then the unit's bytes.
	always_comb begin
		held_enc = encode_cp({5'd0, u16u8_pkg::SURR_HIGH_TAG, held_bits_q});
		unit_enc = pair ? encode_cp(pair_cp) : encode_cp({5'd0, unit_s1});
		unit_cnt = hold ? 3'd0 : unit_enc.count;
		for (int i = 0; i < u16u8_pkg::MAX_BYTES; i++) begin
			enc_bytes[i] = '0;
		end
		if (flush) begin
			for (int i = 0; i < 3; i++) begin
				enc_bytes[i]     = held_enc.bytes[i];
				enc_bytes[i + 3] = unit_enc.bytes[i];
			end
			enc_cnt = 3'd3 + unit_cnt;
		end else begin
			for (int i = 0; i < 4; i++) begin
				enc_bytes[i] = unit_enc.bytes[i];
			end
			enc_cnt = unit_cnt;
		end
	end

	// Flow control between the stages.
	always_comb begin
		take       = valid_s2 && byte_ready;
		last_byte  = (idx_s2 == (cnt_s2 - 3'd1));
		buf_free   = !valid_s2 || (take && last_byte);
		consume    = valid_s1 && ((enc_cnt == 3'd0) || buf_free);
		unit_ready = !valid_s1 || consume;
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (unit_ready) begin
			valid_s1 <= unit_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (unit_valid && unit_ready) begin
			unit_s1 <= unit_data.code_unit;
			fin_s1  <= unit_data.final_unit;
		end
	end

	// Surrogate holding state, updated as each unit is encoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (consume) begin
			held_valid_q <= hold;
			held_bits_q  <= hold ? unit_s1[9:0] : 10'd0;
		end
	end

	// Byte buffer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
			cnt_s2   <= '0;
		end else if (consume && (enc_cnt != 3'd0)) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
			cnt_s2   <= enc_cnt;
		end else if (take) begin
			if (last_byte) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 3'd1;
			end
		end
	end

	// Byte buffer payload.
	always_ff @(posedge clk) begin
		if (consume && (enc_cnt != 3'd0)) begin
			bytes_s2 <= enc_bytes;
			fin_s2   <= fin_s1;
		end
	end

	// Output transaction.
	always_comb begin
		byte_valid           = valid_s2;
		byte_data.out_byte   = bytes_s2[idx_s2];
		byte_data.run_end    = last_byte;
		byte_data.string_end = last_byte && fin_s2;
	end

endmodule

[design/u16u8_checker.sv]
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder port checker
// Watches the encoder's ports for well-formed UTF-8 and sound end markers.
// ----------------------------------------------------------------------------
module u16u8_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input u16u8_pkg::byte_item_t byte_data
);

	// No byte is offered while reset is applied.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !byte_valid)
		else $error("byte offered during reset");

	// A stalled byte transaction holds until taken.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_ready |=> byte_valid && $stable(byte_data))
		else $error("byte transaction changed while stalled");

	// The end of a string is always the end of a run.
	a_string_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_data.string_end |-> byte_data.run_end)
		else $error("string_end without run_end");

	// A run never ends on a multi-byte lead byte.
	a_run_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_data.run_end |-> byte_data.out_byte[7:6] != 2'b11)
		else $error("run ends on a lead byte");

	// Bytes that never occur in UTF-8 output.
	a_legal_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> byte_data.out_byte[7:3] != 5'b11111 &&
		               byte_data.out_byte != 8'hc0 && byte_data.out_byte != 8'hc1)
		else $error("illegal UTF-8 byte");

endmodule

bind utf16_to_utf8_encoder_top u16u8_checker u_u16u8_checker (.*);
